### hw/rtl/crfa_pkg.sv
`default_nettype none
package crfa_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 16;
  localparam int CELL_BITS = 32;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int RIU_W     = ROW_W + 1;
  localparam int DEPTH     = MAX_ROWS * MAX_COLS;
  localparam int CNT_W     = $clog2(CELL_BITS);

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_FOLD  = 2'd1,
    REQ_APPLY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    OP_ASSIGN = 4'd0,
    OP_MOD    = 4'd1,
    OP_DIV    = 4'd2,
    OP_SHL    = 4'd3,
    OP_SHR    = 4'd4,
    OP_ADD    = 4'd5,
    OP_SUB    = 4'd6,
    OP_AND    = 4'd7,
    OP_OR     = 4'd8,
    OP_XOR    = 4'd9,
    OP_MUL    = 4'd10,
    OP_MAX    = 4'd11,
    OP_MIN    = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RADDR,
    S_RDATA,
    S_ALU,
    S_DONE
  } ctl_st_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIN,
    A_OUT
  } alu_st_t;

  typedef struct packed {
    logic       start;
    logic [3:0] code;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic dz;
  } alu_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/crfa_mem.sv
`default_nettype none
module crfa_mem
  import crfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [CELL_BITS:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [CELL_BITS:0] rd_data
);

  logic [CELL_BITS:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/crfa_alu.sv
`default_nettype none
module crfa_alu
  import crfa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  alu_req_t                  req,
  input  wire logic [CELL_BITS-1:0] a,
  input  wire logic [CELL_BITS-1:0] b,
  output alu_rsp_t                  rsp,
  output logic      [CELL_BITS-1:0] res
);

  alu_st_t              st_r, st_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CELL_BITS-1:0] rem_r, rem_nxt;
  logic [CELL_BITS-1:0] quo_r, quo_nxt;
  logic [CELL_BITS-1:0] mb_r, mb_nxt;
  logic                 negq_r, negq_nxt;
  logic                 negr_r, negr_nxt;
  logic                 isdiv_r, isdiv_nxt;
  logic [CELL_BITS-1:0] res_r, res_nxt;
  logic                 done_r, done_nxt;
  logic                 dz_r, dz_nxt;
  logic [CELL_BITS:0]   trial;

  function automatic logic [CELL_BITS-1:0] simple_op(
    input logic [3:0]           code,
    input logic [CELL_BITS-1:0] x,
    input logic [CELL_BITS-1:0] y
  );
    logic [CELL_BITS-1:0] r;
    logic                 big;
    logic                 xlt;
    big = |y[CELL_BITS-1:CNT_W];
    xlt = $signed(x) < $signed(y);
    unique case (code)
      OP_ASSIGN: r = y;
      OP_SHL:    r = big ? '0 : x << y[CNT_W-1:0];
      OP_SHR:    r = big ? {CELL_BITS{x[CELL_BITS-1]}}
                         : CELL_BITS'($signed(x) >>> y[CNT_W-1:0]);
      OP_ADD:    r = x + y;
      OP_SUB:    r = x - y;
      OP_AND:    r = (x == '0) ? y : ((y == '0) ? x : (x & y));
      OP_OR:     r = x | y;
      OP_XOR:    r = x ^ y;
      OP_MUL:    r = (x == '0) ? y : ((y == '0) ? x : CELL_BITS'(x * y));
      OP_MAX:    r = ($signed(y) < $signed(x)) ? x : y;
      OP_MIN:    r = xlt ? ((x != '0) ? x : y) : ((y != '0) ? y : x);
      default:   r = x;
    endcase
    return r;
  endfunction

  // restoring divide step on magnitudes
  assign trial = {rem_r, quo_r[CELL_BITS-1]} - {1'b0, mb_r};

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    mb_nxt    = mb_r;
    negq_nxt  = negq_r;
    negr_nxt  = negr_r;
    isdiv_nxt = isdiv_r;
    res_nxt   = res_r;
    done_nxt  = 1'b0;
    dz_nxt    = 1'b0;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          if (req.code == OP_DIV || req.code == OP_MOD) begin
            if (b == '0) begin
              res_nxt  = '0;
              dz_nxt   = 1'b1;
              done_nxt = 1'b1;
            end else begin
              quo_nxt   = a[CELL_BITS-1] ? -a : a;
              mb_nxt    = b[CELL_BITS-1] ? -b : b;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              negq_nxt  = a[CELL_BITS-1] ^ b[CELL_BITS-1];
              negr_nxt  = a[CELL_BITS-1];
              isdiv_nxt = (req.code == OP_DIV);
              st_nxt    = A_DIV;
            end
          end else begin
            res_nxt  = simple_op(req.code, a, b);
            done_nxt = 1'b1;
          end
        end
      end
      A_DIV: begin
        if (!trial[CELL_BITS]) begin
          rem_nxt = trial[CELL_BITS-1:0];
          quo_nxt = {quo_r[CELL_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[CELL_BITS-2:0], quo_r[CELL_BITS-1]};
          quo_nxt = {quo_r[CELL_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          st_nxt = A_FIN;
        end
      end
      A_FIN: begin
        if (isdiv_r) begin
          res_nxt = negq_r ? -quo_r : quo_r;
        end else begin
          res_nxt = negr_r ? -rem_r : rem_r;
        end
        st_nxt = A_OUT;
      end
      A_OUT: begin
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    mb_r    <= mb_nxt;
    negq_r  <= negq_nxt;
    negr_r  <= negr_nxt;
    isdiv_r <= isdiv_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.dz   = dz_r;
  assign res      = res_r;

endmodule
`default_nettype wire

### hw/rtl/column_range_fold_and_apply.sv
`default_nettype none
// channel | ports                     | tdata (low bit up)                      | tuser
// in      | in_tvalid/in_tready       | row_first, row_second, column_sel,      | req_type
//         |                           | operator_code, operand_value            |
// out     | out_tvalid/out_tready     | result_value, dirty_first_row,          | cell_present,
//         |                           | dirty_last_row                          | error_code
//
// One request at a time. Fold and apply visit each row in turn: memory read,
// shared ALU, then write back for apply or accumulate for fold (for div/mod
// the ALU divides one bit a cycle).
// After reset a clearing pass writes all 16384 cells, one per cycle; in_tready
// stays low during it. A result waits in the output register until taken.
module column_range_fold_and_apply
  import crfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,  // row_first, row_second, column_sel, operator_code,
                                      // operand_value, zero pad
  input  wire logic [1:0]  in_tuser,  // req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata, // result_value, dirty_first_row, dirty_last_row, pad
  output logic      [2:0]  out_tuser  // cell_present, error_code
);

  ctl_st_t              state_r, state_nxt;
  logic [1:0]           req_r, req_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [ROW_W-1:0]     end_r, end_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [3:0]           code_r, code_nxt;
  logic [CELL_BITS-1:0] n_r, n_nxt;
  logic [CELL_BITS-1:0] acc_r, acc_nxt;
  logic                 pres_r, pres_nxt;
  logic [1:0]           err_r, err_nxt;
  logic                 dz_r, dz_nxt;
  logic [RIU_W-1:0]     riu_r, riu_nxt;
  logic [ROW_W-1:0]     dlo_r, dlo_nxt;
  logic [ROW_W-1:0]     dhi_r, dhi_nxt;
  logic [ADDR_W-1:0]    clr_r, clr_nxt;
  logic                 ov_r, ov_nxt;
  logic [55:0]          od_r, od_nxt;
  logic [2:0]           ou_r, ou_nxt;

  logic [ROW_W-1:0]     in_r1, in_r2, t_lo, t_hi;
  logic [COL_W-1:0]     in_col;
  logic [RIU_W-1:0]     hi_ext;

  logic                 wr_en, rd_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [CELL_BITS:0]   wr_data, rd_data;
  logic [CELL_BITS-1:0] cell_val, alu_a, alu_b, alu_res;
  alu_req_t             areq;
  alu_rsp_t             arsp;

  assign in_r1  = in_tdata[9:0];
  assign in_r2  = in_tdata[19:10];
  assign in_col = in_tdata[23:20];
  assign t_lo   = (in_r1 < in_r2) ? in_r1 : in_r2;
  assign t_hi   = (in_r1 < in_r2) ? in_r2 : in_r1;
  assign hi_ext = {1'b0, t_hi};
  assign cell_val = rd_data[CELL_BITS] ? rd_data[CELL_BITS-1:0] : '0;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    row_nxt   = row_r;
    end_nxt   = end_r;
    col_nxt   = col_r;
    code_nxt  = code_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    pres_nxt  = pres_r;
    err_nxt   = err_r;
    dz_nxt    = dz_r;
    riu_nxt   = riu_r;
    dlo_nxt   = dlo_r;
    dhi_nxt   = dhi_r;
    clr_nxt   = clr_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    wr_en     = 1'b0;
    wr_addr   = {row_r, col_r};
    wr_data   = {1'b1, alu_res};
    rd_en     = 1'b0;
    areq.start = 1'b0;
    areq.code  = code_r;
    alu_a     = (req_r == REQ_FOLD) ? acc_r : cell_val;
    alu_b     = (req_r == REQ_FOLD) ? cell_val : n_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          req_nxt  = in_tuser;
          row_nxt  = t_lo;
          end_nxt  = t_hi;
          col_nxt  = in_col;
          code_nxt = in_tdata[27:24];
          n_nxt    = in_tdata[59:28];
          acc_nxt  = '0;
          pres_nxt = 1'b0;
          err_nxt  = ERR_NONE;
          dz_nxt   = 1'b0;
          state_nxt = S_DONE;
          if (in_tuser != REQ_NONE && int'(in_col) >= MAX_COLS) begin
            err_nxt = ERR_RANGE;
          end else begin
            unique case (in_tuser)
              REQ_READ: begin
                if (int'(in_r1) >= MAX_ROWS) begin
                  err_nxt = ERR_RANGE;
                end else begin
                  if (in_r1 < dlo_r) dlo_nxt = in_r1;
                  if (in_r1 > dhi_r) dhi_nxt = in_r1;
                  row_nxt   = in_r1;
                  end_nxt   = in_r1;
                  state_nxt = S_RADDR;
                end
              end
              REQ_FOLD: begin
                if (t_lo < dlo_r) dlo_nxt = t_lo;
                if (t_hi > dhi_r) dhi_nxt = t_hi;
                if (riu_r != '0) begin
                  if (hi_ext >= riu_r) begin
                    end_nxt = ROW_W'(riu_r - 1'b1);
                  end
                  if ({1'b0, t_lo} < riu_r) begin
                    state_nxt = S_RADDR;
                  end
                end
              end
              REQ_APPLY: begin
                if (int'(t_hi) >= MAX_ROWS) begin
                  err_nxt = ERR_RANGE;
                end else begin
                  if (t_lo < dlo_r) dlo_nxt = t_lo;
                  if (t_hi > dhi_r) dhi_nxt = t_hi;
                  if (hi_ext + 1'b1 > riu_r) riu_nxt = hi_ext + 1'b1;
                  state_nxt = S_RADDR;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_RADDR: begin
        rd_en     = 1'b1;
        state_nxt = S_RDATA;
      end
      S_RDATA: begin
        if (req_r == REQ_READ) begin
          pres_nxt  = rd_data[CELL_BITS];
          acc_nxt   = cell_val;
          state_nxt = S_DONE;
        end else begin
          areq.start = 1'b1;
          state_nxt  = S_ALU;
        end
      end
      S_ALU: begin
        if (arsp.done) begin
          if (arsp.dz) dz_nxt = 1'b1;
          if (req_r == REQ_FOLD) begin
            acc_nxt = alu_res;
          end else begin
            wr_en = 1'b1;
          end
          if (row_r == end_r) begin
            state_nxt = S_DONE;
          end else begin
            row_nxt   = row_r + 1'b1;
            state_nxt = S_RADDR;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {4'd0, dhi_r, dlo_r, acc_r};
          if (err_r != ERR_NONE) begin
            ou_nxt = {err_r, pres_r};
          end else if (dz_r) begin
            ou_nxt = {ERR_DIV0, pres_r};
          end else begin
            ou_nxt = {ERR_NONE, pres_r};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      riu_r   <= '0;
      dlo_r   <= '1;
      dhi_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      riu_r   <= riu_nxt;
      dlo_r   <= dlo_nxt;
      dhi_r   <= dhi_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    row_r  <= row_nxt;
    end_r  <= end_nxt;
    col_r  <= col_nxt;
    code_r <= code_nxt;
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    pres_r <= pres_nxt;
    err_r  <= err_nxt;
    dz_r   <= dz_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
  end

  crfa_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr ({row_r, col_r}),
    .rd_data (rd_data)
  );

  crfa_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (areq),
    .a     (alu_a),
    .b     (alu_b),
    .rsp   (arsp),
    .res   (alu_res)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule
`default_nettype wire

### hw/rtl/crfa_checker.sv
`default_nettype none
module crfa_checker
  import crfa_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [63:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second request back to back");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[2:1] != 2'b11)
    else $error("undefined error code");

  // present bit only on a result with no error
  a_pres_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ERR_NONE)
    else $error("present flag with error");

endmodule

bind column_range_fold_and_apply crfa_checker u_chk (.*);
`default_nettype wire
